// ===== rtl/core/rotate_source_coordinate_top_assert.svh =====
// Assertion macros for the rotate_source_coordinate block.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ROTATE_SOURCE_COORDINATE_TOP_ASSERT_SVH
`define ROTATE_SOURCE_COORDINATE_TOP_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define RSC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotate_source_coordinate: assertion failed");

// Check that cons holds in the cycle after ante.
`define RSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotate_source_coordinate: assertion failed");

`endif

// ===== rtl/core/rsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rsc_pkg
// Widths, register indexes and shared types of the source coordinate pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

    localparam int COORD_W   = 13;                   // pixel coordinate fields
    localparam int SIZE_W    = 14;                   // image size registers
    localparam int COEF_W    = 16;                   // Q1.14 cosine and sine
    localparam int FRAC_BITS = 14;
    localparam int DELTA_W   = COORD_W + 1;          // signed offset from the centre
    localparam int PROD_W    = COEF_W + DELTA_W;     // one coefficient product
    localparam int SUM_W     = PROD_W + 2;           // sum of two products plus bias
    localparam int CEIL_W    = SUM_W - FRAC_BITS;    // rotated offset after ceiling
    localparam int POS_W     = CEIL_W + 1;           // offset plus source centre
    localparam int MAX_DIM   = 8192;
    localparam int CFG_IDX_W = 3;

    localparam logic [SUM_W-1:0] CEIL_BIAS = SUM_W'((1 << FRAC_BITS) - 1);
    localparam logic [POS_W-1:0] MAX_POS   = POS_W'(MAX_DIM);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_COS_Q      = 3'd4,
        CFG_SIN_Q      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic        [SIZE_W-1:0] src_width;
        logic        [SIZE_W-1:0] src_height;
        logic        [SIZE_W-1:0] dst_width;
        logic        [SIZE_W-1:0] dst_height;
        logic signed [COEF_W-1:0] cos_q;
        logic signed [COEF_W-1:0] sin_q;
    } cfg_t;

    // Offset of the destination pixel from the destination centre.
    typedef struct packed {
        logic                      valid;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } delta_beat_t;

    // Rotated offset, already rounded up.
    typedef struct packed {
        logic                     valid;
        logic signed [CEIL_W-1:0] rx;
        logic signed [CEIL_W-1:0] ry;
    } rot_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/rotate_source_coordinate_top.sv =====
// ----------------------------------------------------------------------------
// rotate_source_coordinate_top
// Inverse rotation of destination pixel coordinates into the source image.
// ----------------------------------------------------------------------------
// Usage:
//   Program src/dst sizes and the Q1.14 cosine and sine through cfg_wr_en,
//   cfg_addr and cfg_wdata while no beat is in flight; a write lands at the
//   clock edge and indexes beyond the sine register are ignored.
//   Present a destination pixel on dest_x/dest_y with start high; busy is
//   always low, so a beat is taken every cycle start is high.
//   Once a beat has passed the pipeline, done is high for one cycle with
//   source_x, source_y and inside_res. Coordinates are zero when the point
//   falls outside the source image.
//   Throughput is one beat per clock; each beat passes in turn through the
//   offset stage, the product stage, the rounding adder stage and the
//   bounds/output stage.
//   There is no output backpressure: the receiver takes done when it appears.
//   Reset clears all in-flight beats and loads the default registers
//   (sizes 1, cosine 1.0, sine 0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rotate_source_coordinate_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [rsc_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [rsc_pkg::COEF_W-1:0]      cfg_wdata,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [rsc_pkg::COORD_W-1:0]     dest_x,
    input  wire logic [rsc_pkg::COORD_W-1:0]     dest_y,
    output logic                                 done,
    output logic [rsc_pkg::COORD_W-1:0]          source_x,
    output logic [rsc_pkg::COORD_W-1:0]          source_y,
    output logic                                 inside_res
);

    `include "rotate_source_coordinate_top_assert.svh"

    rsc_pkg::cfg_t        cfg_reg;
    rsc_pkg::delta_beat_t delta;
    rsc_pkg::rot_beat_t   rot;

    // Pipeline takes a beat every cycle
    assign busy = 1'b0;

    // Decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= rsc_pkg::SIZE_W'(1);
            cfg_reg.src_height <= rsc_pkg::SIZE_W'(1);
            cfg_reg.dst_width  <= rsc_pkg::SIZE_W'(1);
            cfg_reg.dst_height <= rsc_pkg::SIZE_W'(1);
            cfg_reg.cos_q      <= rsc_pkg::COEF_W'(1 << rsc_pkg::FRAC_BITS);
            cfg_reg.sin_q      <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (rsc_pkg::cfg_idx_t'(cfg_addr))
                rsc_pkg::CFG_SRC_WIDTH:  cfg_reg.src_width  <= cfg_wdata[rsc_pkg::SIZE_W-1:0];
                rsc_pkg::CFG_SRC_HEIGHT: cfg_reg.src_height <= cfg_wdata[rsc_pkg::SIZE_W-1:0];
                rsc_pkg::CFG_DST_WIDTH:  cfg_reg.dst_width  <= cfg_wdata[rsc_pkg::SIZE_W-1:0];
                rsc_pkg::CFG_DST_HEIGHT: cfg_reg.dst_height <= cfg_wdata[rsc_pkg::SIZE_W-1:0];
                rsc_pkg::CFG_COS_Q:      cfg_reg.cos_q      <= cfg_wdata;
                rsc_pkg::CFG_SIN_Q:      cfg_reg.sin_q      <= cfg_wdata;
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    rsc_offset u_offset (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .dest_x   (dest_x),
        .dest_y   (dest_y),
        .cfg      (cfg_reg),
        .delta    (delta)
    );

    rsc_rotate u_rotate (
        .clk   (clk),
        .rst_n (rst_n),
        .delta (delta),
        .cfg   (cfg_reg),
        .rot   (rot)
    );

    rsc_bounds u_bounds (
        .clk        (clk),
        .rst_n      (rst_n),
        .rot        (rot),
        .cfg        (cfg_reg),
        .done       (done),
        .source_x   (source_x),
        .source_y   (source_y),
        .inside_res (inside_res)
    );

    // Every accepted beat comes out as done after the offset, product, rounding and output registers
    `RSC_ASSERT_NEXT(a_latency, start && !busy, ##3 done)
    // A rounded beat always reaches the output register next cycle
    `RSC_ASSERT_NEXT(a_rot_to_done, rot.valid, done)
    // An outside point reports zero coordinates
    `RSC_ASSERT_SAME(a_outside_zero, done && !inside_res, source_x == '0 && source_y == '0)
    // An inside point lies below the source size
    `RSC_ASSERT_SAME(a_inside_bound, done && inside_res,
        rsc_pkg::SIZE_W'(source_x) < cfg_reg.src_width
        && rsc_pkg::SIZE_W'(source_y) < cfg_reg.src_height)

endmodule

`default_nettype wire

// ===== rtl/core/rsc_offset.sv =====
// ----------------------------------------------------------------------------
// rsc_offset
// Stage 1: subtract the destination centre from the incoming coordinate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsc_offset (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [rsc_pkg::COORD_W-1:0]   dest_x,
    input  wire logic [rsc_pkg::COORD_W-1:0]   dest_y,
    input  wire rsc_pkg::cfg_t                 cfg,
    output rsc_pkg::delta_beat_t               delta
);

    logic                               valid_reg;
    logic signed [rsc_pkg::DELTA_W-1:0] dx_reg;
    logic signed [rsc_pkg::DELTA_W-1:0] dy_reg;
    logic signed [rsc_pkg::DELTA_W-1:0] dx_next;
    logic signed [rsc_pkg::DELTA_W-1:0] dy_next;

    // Centre is the truncated half of each destination size
    always_comb
    begin
        dx_next = rsc_pkg::DELTA_W'({1'b0, dest_x})
                - rsc_pkg::DELTA_W'({1'b0, cfg.dst_width[rsc_pkg::SIZE_W-1:1]});
        dy_next = rsc_pkg::DELTA_W'({1'b0, dest_y})
                - rsc_pkg::DELTA_W'({1'b0, cfg.dst_height[rsc_pkg::SIZE_W-1:1]});
    end

    // Advance the valid bit every cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold the offsets of the beat
    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dy_reg <= dy_next;
    end

    assign delta.valid = valid_reg;
    assign delta.dx    = dx_reg;
    assign delta.dy    = dy_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rsc_rotate.sv =====
// ----------------------------------------------------------------------------
// rsc_rotate
// Stages 2 and 3: four coefficient products, then the two sums rounded up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsc_rotate (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rsc_pkg::delta_beat_t  delta,
    input  wire rsc_pkg::cfg_t         cfg,
    output rsc_pkg::rot_beat_t         rot
);

    logic                              prod_valid_reg;
    logic signed [rsc_pkg::PROD_W-1:0] cdx_reg;
    logic signed [rsc_pkg::PROD_W-1:0] sdy_reg;
    logic signed [rsc_pkg::PROD_W-1:0] cdy_reg;
    logic signed [rsc_pkg::PROD_W-1:0] sdx_reg;
    logic signed [rsc_pkg::PROD_W-1:0] cdx_next;
    logic signed [rsc_pkg::PROD_W-1:0] sdy_next;
    logic signed [rsc_pkg::PROD_W-1:0] cdy_next;
    logic signed [rsc_pkg::PROD_W-1:0] sdx_next;

    logic                              rot_valid_reg;
    logic [rsc_pkg::CEIL_W-1:0]        rx_reg;
    logic [rsc_pkg::CEIL_W-1:0]        ry_reg;
    logic [rsc_pkg::SUM_W-1:0]         sum_x;
    logic [rsc_pkg::SUM_W-1:0]         sum_y;

    // Multiply each offset by both coefficients
    always_comb
    begin
        cdx_next = rsc_pkg::PROD_W'(cfg.cos_q) * rsc_pkg::PROD_W'(delta.dx);
        sdy_next = rsc_pkg::PROD_W'(cfg.sin_q) * rsc_pkg::PROD_W'(delta.dy);
        cdy_next = rsc_pkg::PROD_W'(cfg.cos_q) * rsc_pkg::PROD_W'(delta.dy);
        sdx_next = rsc_pkg::PROD_W'(cfg.sin_q) * rsc_pkg::PROD_W'(delta.dx);
    end

    // Add the products with the rounding bias; the upper bits are the exact ceiling
    always_comb
    begin
        sum_x = {{2{cdx_reg[rsc_pkg::PROD_W-1]}}, cdx_reg}
              + {{2{sdy_reg[rsc_pkg::PROD_W-1]}}, sdy_reg}
              + rsc_pkg::CEIL_BIAS;
        sum_y = {{2{cdy_reg[rsc_pkg::PROD_W-1]}}, cdy_reg}
              - {{2{sdx_reg[rsc_pkg::PROD_W-1]}}, sdx_reg}
              + rsc_pkg::CEIL_BIAS;
    end

    // Advance valid bits through both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            rot_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= delta.valid;
            rot_valid_reg  <= prod_valid_reg;
        end
    end

    // Hold products and rounded sums
    always_ff @(posedge clk)
    begin
        cdx_reg <= cdx_next;
        sdy_reg <= sdy_next;
        cdy_reg <= cdy_next;
        sdx_reg <= sdx_next;
        rx_reg  <= sum_x[rsc_pkg::SUM_W-1:rsc_pkg::FRAC_BITS];
        ry_reg  <= sum_y[rsc_pkg::SUM_W-1:rsc_pkg::FRAC_BITS];
    end

    assign rot.valid = rot_valid_reg;
    assign rot.rx    = rx_reg;
    assign rot.ry    = ry_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rsc_bounds.sv =====
// ----------------------------------------------------------------------------
// rsc_bounds
// Stage 4: add the source centre, check the bounds and register the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsc_bounds (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire rsc_pkg::rot_beat_t            rot,
    input  wire rsc_pkg::cfg_t                 cfg,
    output logic                               done,
    output logic [rsc_pkg::COORD_W-1:0]        source_x,
    output logic [rsc_pkg::COORD_W-1:0]        source_y,
    output logic                               inside_res
);

    logic                         done_reg;
    logic [rsc_pkg::COORD_W-1:0]  source_x_reg;
    logic [rsc_pkg::COORD_W-1:0]  source_y_reg;
    logic                         inside_reg;
    logic [rsc_pkg::POS_W-1:0]    bx;
    logic [rsc_pkg::POS_W-1:0]    by;
    logic                         in_x;
    logic                         in_y;
    logic                         inside_next;

    // Shift by the source centre, then test 0 <= pos < size and pos < MAX_DIM
    always_comb
    begin
        bx = {rot.rx[rsc_pkg::CEIL_W-1], rot.rx}
           + rsc_pkg::POS_W'(cfg.src_width[rsc_pkg::SIZE_W-1:1]);
        by = {rot.ry[rsc_pkg::CEIL_W-1], rot.ry}
           + rsc_pkg::POS_W'(cfg.src_height[rsc_pkg::SIZE_W-1:1]);
        in_x = !bx[rsc_pkg::POS_W-1]
             && (bx < rsc_pkg::POS_W'(cfg.src_width))
             && (bx < rsc_pkg::MAX_POS);
        in_y = !by[rsc_pkg::POS_W-1]
             && (by < rsc_pkg::POS_W'(cfg.src_height))
             && (by < rsc_pkg::MAX_POS);
        inside_next = in_x && in_y;
    end

    // Strobe one result per valid beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rot.valid;
        end
    end

    // Drop the coordinates to zero for an outside point
    always_ff @(posedge clk)
    begin
        inside_reg   <= inside_next;
        source_x_reg <= inside_next ? bx[rsc_pkg::COORD_W-1:0] : '0;
        source_y_reg <= inside_next ? by[rsc_pkg::COORD_W-1:0] : '0;
    end

    assign done       = done_reg;
    assign source_x   = source_x_reg;
    assign source_y   = source_y_reg;
    assign inside_res = inside_reg;

endmodule

`default_nettype wire
